@@ rtl/stok_pkg.sv @@
`default_nettype none
package stok_pkg;

    typedef enum logic [4:0] {
        M_IDLE, M_COLON, M_EQ, M_GT, M_LT, M_SLASH, M_PIPE, M_LPAREN, M_DASH,
        M_INT, M_DOT, M_FRAC, M_STR, M_STR_BS, M_COM, M_COM_STAR, M_IDENT, M_ERR
    } t_mode;

    localparam int KW_N = 14;

    localparam logic [5:0] K_LBRACE   = 6'd0;
    localparam logic [5:0] K_RBRACE   = 6'd1;
    localparam logic [5:0] K_LPAREN   = 6'd2;
    localparam logic [5:0] K_RPAREN   = 6'd3;
    localparam logic [5:0] K_COMMA    = 6'd4;
    localparam logic [5:0] K_COLON    = 6'd5;
    localparam logic [5:0] K_DCOLON   = 6'd6;
    localparam logic [5:0] K_EQUAL    = 6'd7;
    localparam logic [5:0] K_EQEQ     = 6'd8;
    localparam logic [5:0] K_ARROW    = 6'd9;
    localparam logic [5:0] K_GT       = 6'd10;
    localparam logic [5:0] K_GE       = 6'd11;
    localparam logic [5:0] K_LT       = 6'd12;
    localparam logic [5:0] K_LE       = 6'd13;
    localparam logic [5:0] K_LARROW   = 6'd14;
    localparam logic [5:0] K_PLUS     = 6'd15;
    localparam logic [5:0] K_STAR     = 6'd16;
    localparam logic [5:0] K_UNDER    = 6'd17;
    localparam logic [5:0] K_DASH     = 6'd18;
    localparam logic [5:0] K_SLASH    = 6'd19;
    localparam logic [5:0] K_NE       = 6'd20;
    localparam logic [5:0] K_PIPEGT   = 6'd21;
    localparam logic [5:0] K_NUMBER   = 6'd22;
    localparam logic [5:0] K_STRING   = 6'd23;
    localparam logic [5:0] K_IDENT    = 6'd24;
    localparam logic [5:0] K_KW0      = 6'd25;
    localparam logic [5:0] E_BYTE     = 6'd39;
    localparam logic [5:0] E_PIPE     = 6'd40;
    localparam logic [5:0] E_COMMENT  = 6'd41;
    localparam logic [5:0] E_FRAC     = 6'd42;
    localparam logic [5:0] E_STRING   = 6'd43;
    localparam logic [5:0] K_END      = 6'd44;

    function automatic logic [3:0] kw_len(input int k);
        logic [3:0] r;
        unique case (k)
            0: r = 4'd7;  1: r = 4'd3;  2: r = 4'd2;  3: r = 4'd2;
            4: r = 4'd4;  5: r = 4'd5;  6: r = 4'd5;  7: r = 4'd9;
            8: r = 4'd3;  9: r = 4'd5;  10: r = 4'd3; 11: r = 4'd7;
            12: r = 4'd3; default: r = 4'd2;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_char(input int k, input logic [3:0] p);
        logic [71:0] s;
        logic [3:0]  q;
        unique case (k)
            0: s = "discard"; 1: s = "let"; 2: s = "in"; 3: s = "do";
            4: s = "unit"; 5: s = "cases"; 6: s = "given"; 7: s = "otherwise";
            8: s = "end"; 9: s = "while"; 10: s = "not"; 11: s = "perform";
            12: s = "and"; default: s = "or";
        endcase
        q = kw_len(k) - 4'd1 - p;
        return s[{q, 3'b000} +: 8];
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_dec(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
            || c == "." || c == "_";
    endfunction

endpackage
`default_nettype wire

@@ rtl/stok_if.sv @@
`default_nettype none
interface stok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    modport source (output valid, ch, input ready);
    modport sink (input valid, ch, output ready);
endinterface

interface stok_out_if #(
    parameter int OFFSET_BITS = 20,
    parameter int LINE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [5:0]             kind;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [OFFSET_BITS-1:0] end_offset;
    logic [LINE_BITS-1:0]   line;
    logic                   last;
    modport source (output valid, kind, start_offset, end_offset, line, last, input ready);
    modport sink (input valid, kind, start_offset, end_offset, line, last, output ready);
endinterface
`default_nettype wire

@@ rtl/source_tokenizer_top.sv @@
`default_nettype none
// Results of a byte are registered and appear in the cycle after it is accepted.
// Throughput: one byte per cycle while the output is not stalled; a byte producing two
// results holds off the input until its first result has been taken.
// Reset: synchronous active low; lexer idle, offsets zero, line = first_line.
module source_tokenizer_top #(
    parameter int OFFSET_BITS = 20,
    parameter int LINE_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    stok_in_if.sink          i_src,
    stok_out_if.source       o_tok
);
    import stok_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
    localparam logic [LINE_BITS-1:0]   LIN_MAX = '1;

    typedef struct packed {
        logic [5:0]             kind;
        logic [OFFSET_BITS-1:0] s;
        logic [OFFSET_BITS-1:0] e;
        logic [LINE_BITS-1:0]   line;
    } t_res;

    logic [15:0]            r_first;
    t_mode                  r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_off, n_off, r_start, n_start;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [13:0]            r_cand, n_cand;
    logic [3:0]             r_len, n_len;
    logic [1:0]             r_cnt;
    t_res                   r_q0, r_q1;

    logic [LINE_BITS-1:0]   first_sat;
    logic [13:0]            kw_cand;
    logic [3:0]             kw_len_n;
    logic [5:0]             kw_kind;
    logic                   acc;
    t_res                   res [2];
    logic [1:0]             nres;

    stok_kw u_kw (.i_cand((r_mode == M_IDENT) ? r_cand : 14'h3FFF),
                  .i_len((r_mode == M_IDENT) ? r_len : 4'd0), .i_ch(i_src.ch),
                  .o_cand(kw_cand), .o_len(kw_len_n), .o_kind(kw_kind));

    always_comb begin
        if (LINE_BITS >= 16) first_sat = LINE_BITS'(r_first);
        else if (|(32'(r_first) >> LINE_BITS)) first_sat = LIN_MAX;
        else first_sat = LINE_BITS'(r_first);
    end

    assign i_src.ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && o_tok.ready);
    assign acc = i_src.valid && i_src.ready;

    always_comb begin
        logic [7:0]             c;
        logic [OFFSET_BITS-1:0] e;
        logic [5:0]             two;
        logic                   took, idle_go, err;
        logic [5:0]             fk;
        c = i_src.ch;
        e = (r_off == OFF_MAX) ? OFF_MAX : r_off + 1'b1;
        n_mode = r_mode; n_off = r_off; n_start = r_start; n_line = r_line;
        n_cand = r_cand; n_len = r_len; nres = 2'd0;
        res[0] = '0; res[1] = '0;
        two = '0; took = 1'b0; idle_go = 1'b0; err = 1'b0; fk = '0;
        if (c == 8'd0) begin
            if (r_mode != M_IDLE && r_mode != M_ERR) begin
                unique case (r_mode)
                    M_COLON: fk = K_COLON;
                    M_EQ: fk = K_EQUAL;
                    M_GT: fk = K_GT;
                    M_LT: fk = K_LT;
                    M_SLASH: fk = K_SLASH;
                    M_DASH: fk = K_DASH;
                    M_INT, M_FRAC: fk = K_NUMBER;
                    M_IDENT: fk = kw_kind;
                    M_PIPE: fk = E_PIPE;
                    M_DOT: fk = E_FRAC;
                    M_STR, M_STR_BS: fk = E_STRING;
                    default: fk = E_COMMENT;
                endcase
                res[0] = '{fk, r_start, r_off, r_line};
                nres = 2'd1;
            end
            res[nres[0]] = '{K_END, r_off, r_off, r_line};
            nres = nres + 2'd1;
            n_mode = M_IDLE; n_off = '0; n_line = first_sat; n_start = '0;
            n_cand = 14'h3FFF; n_len = '0;
        end else begin
            n_off = e;
            if (r_mode == M_IDLE) idle_go = 1'b1;
            else if (r_mode != M_ERR) begin
                unique case (r_mode)
                    M_COLON: if (c == ":") two = K_DCOLON;
                    M_EQ: if (c == ">") two = K_ARROW; else if (c == "=") two = K_EQEQ;
                    M_GT: if (c == "=") two = K_GE;
                    M_LT: if (c == "=") two = K_LE; else if (c == "-") two = K_LARROW;
                    M_SLASH: if (c == "=") two = K_NE;
                    M_PIPE: if (c == ">") two = K_PIPEGT;
                    M_LPAREN: if (c == "*") begin took = 1'b1; n_mode = M_COM; end
                    M_DASH, M_INT: begin
                        if (is_dec(c)) begin took = 1'b1; n_mode = M_INT; end
                        else if (r_mode == M_INT && c == ".") begin
                            took = 1'b1; n_mode = M_DOT;
                        end
                    end
                    M_DOT, M_FRAC: if (is_dec(c)) begin took = 1'b1; n_mode = M_FRAC; end
                    M_IDENT: if (is_ident(c)) begin
                        took = 1'b1; n_cand = kw_cand; n_len = kw_len_n;
                    end
                    M_STR, M_STR_BS: begin
                        took = 1'b1;
                        if (c == "\"" && r_mode == M_STR) begin
                            res[0] = '{K_STRING, (r_start == OFF_MAX) ? OFF_MAX
                                       : r_start + 1'b1, r_off, r_line};
                            nres = 2'd1; n_mode = M_IDLE;
                        end else begin
                            if (c == 8'h0A && r_line != LIN_MAX) n_line = r_line + 1'b1;
                            n_mode = (c == "\\") ? M_STR_BS : M_STR;
                        end
                    end
                    default: begin
                        took = 1'b1;
                        if (c == ")" && r_mode == M_COM_STAR) n_mode = M_IDLE;
                        else begin
                            if (c == 8'h0A && r_line != LIN_MAX) n_line = r_line + 1'b1;
                            n_mode = (c == "*") ? M_COM_STAR : M_COM;
                        end
                    end
                endcase
                if (two != '0) begin
                    took = 1'b1;
                    res[0] = '{two, r_start, e, r_line};
                    nres = 2'd1; n_mode = M_IDLE;
                end
                if (!took) begin
                    unique case (r_mode)
                        M_COLON: fk = K_COLON;
                        M_EQ: fk = K_EQUAL;
                        M_GT: fk = K_GT;
                        M_LT: fk = K_LT;
                        M_SLASH: fk = K_SLASH;
                        M_DASH: fk = K_DASH;
                        M_LPAREN: fk = K_LPAREN;
                        M_INT, M_FRAC: fk = K_NUMBER;
                        M_IDENT: fk = kw_kind;
                        M_PIPE: begin fk = E_PIPE; err = 1'b1; end
                        default: begin fk = E_FRAC; err = 1'b1; end
                    endcase
                    res[0] = '{fk, r_start, r_off, r_line};
                    nres = 2'd1;
                    if (err) n_mode = M_ERR;
                    else idle_go = 1'b1;
                end
            end
            if (idle_go) begin
                n_start = r_off;
                n_mode = M_IDLE;
                fk = 6'h3F;
                unique case (c)
                    "{": fk = K_LBRACE;
                    "}": fk = K_RBRACE;
                    ")": fk = K_RPAREN;
                    ",": fk = K_COMMA;
                    "+": fk = K_PLUS;
                    "*": fk = K_STAR;
                    "_": fk = K_UNDER;
                    "(": n_mode = M_LPAREN;
                    ":": n_mode = M_COLON;
                    "=": n_mode = M_EQ;
                    ">": n_mode = M_GT;
                    "<": n_mode = M_LT;
                    "-": n_mode = M_DASH;
                    "/": n_mode = M_SLASH;
                    "|": n_mode = M_PIPE;
                    "\"": n_mode = M_STR;
                    8'h0A: if (r_line != LIN_MAX) n_line = r_line + 1'b1;
                    " ": ;
                    default: begin
                        if (is_dec(c)) n_mode = M_INT;
                        else if (is_ident(c)) begin
                            n_mode = M_IDENT; n_cand = kw_cand; n_len = kw_len_n;
                        end else begin
                            fk = E_BYTE; n_mode = M_ERR;
                        end
                    end
                endcase
                if (fk != 6'h3F) begin
                    res[nres[0]] = '{fk, r_off, e, r_line};
                    nres = nres + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 16'd1;
            r_mode <= M_IDLE; r_off <= '0; r_start <= '0;
            r_line <= LINE_BITS'(1); r_cand <= 14'h3FFF; r_len <= '0;
            r_cnt <= 2'd0;
        end else begin
            if (i_cfg_we) r_first <= i_cfg_wdata;
            if (acc) begin
                r_mode <= n_mode; r_off <= n_off; r_start <= n_start;
                r_line <= n_line; r_cand <= n_cand; r_len <= n_len;
                r_cnt <= nres;
                r_q0 <= res[0]; r_q1 <= res[1];
            end else if (r_cnt != 2'd0 && o_tok.ready) begin
                r_cnt <= r_cnt - 2'd1;
                r_q0 <= r_q1;
            end
        end
    end

    assign o_tok.valid = r_cnt != 2'd0;
    assign o_tok.kind = r_q0.kind;
    assign o_tok.start_offset = r_q0.s;
    assign o_tok.end_offset = r_q0.e;
    assign o_tok.line = r_q0.line;
    assign o_tok.last = r_cnt == 2'd1;
endmodule
`default_nettype wire

@@ rtl/stok_kw.sv @@
`default_nettype none
module stok_kw (
    input  wire logic [13:0] i_cand,
    input  wire logic [3:0]  i_len,
    input  wire logic [7:0]  i_ch,
    output logic [13:0]      o_cand,
    output logic [3:0]       o_len,
    output logic [5:0]       o_kind
);
    import stok_pkg::*;

    always_comb begin
        o_kind = K_IDENT;
        for (int k = KW_N - 1; k >= 0; k--) begin
            if (i_cand[k] && kw_len(k) == i_len) o_kind = K_KW0 + 6'(k);
        end
        for (int k = 0; k < KW_N; k++) begin
            o_cand[k] = i_cand[k] && kw_len(k) > i_len && kw_char(k, i_len) == i_ch;
        end
        o_len = (i_len == 4'd15) ? i_len : i_len + 4'd1;
    end
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import stok_pkg::*;

    typedef struct packed {
        logic [5:0]  kind;
        logic [19:0] start_offset;
        logic [19:0] end_offset;
        logic [15:0] line;
        logic        last;
    } t_token;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    stok_in_if src_if ();
    stok_out_if #(.OFFSET_BITS(20), .LINE_BITS(16)) tok_if ();

    source_tokenizer_top #(.OFFSET_BITS(20), .LINE_BITS(16)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_src       (src_if),
        .o_tok       (tok_if)
    );

    always #5 i_clk = ~i_clk;

    // lexer mirror
    string       kw_word[KW_N] = '{"discard", "let", "in", "do", "unit", "cases", "given",
                                   "otherwise", "end", "while", "not", "perform", "and", "or"};
    logic [15:0] first_line_reg = 16'd1;
    t_mode       lx_mode;
    logic [19:0] lx_offset;
    logic [15:0] lx_line;
    logic [19:0] lx_start;
    logic [13:0] lx_cands;
    logic [3:0]  lx_len;
    t_token      step_tokens[$];
    t_token      expected_tokens[$];

    int          tx_gap_pct = 0;
    int          rx_stall_pct = 0;
    bit          hold_on = 0;
    int          hold_cnt = 0;
    int          mismatches = 0;
    int          cycles = 0;
    logic [7:0]  text_q[$];

    function automatic void text_add(logic [7:0] c);
        text_q.insert(text_q.size(), c);
    endfunction

    function automatic logic [19:0] offset_inc(logic [19:0] v);
        return (v == 20'hFFFFF) ? v : v + 20'd1;
    endfunction

    function automatic bit digit_char(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit word_char(logic [7:0] c);
        return digit_char(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
            || c == "." || c == "_";
    endfunction

    function automatic void emit(logic [5:0] kind, logic [19:0] s, logic [19:0] e);
        t_token t;
        t.kind = kind;
        t.start_offset = s;
        t.end_offset = e;
        t.line = lx_line;
        t.last = 1'b0;
        step_tokens.insert(step_tokens.size(), t);
    endfunction

    function automatic void line_inc();
        if (lx_line != 16'hFFFF) lx_line++;
    endfunction

    function automatic void lex_restart();
        lx_mode = M_IDLE;
        lx_offset = '0;
        lx_line = first_line_reg;
        lx_start = '0;
        lx_cands = 14'h3FFF;
        lx_len = '0;
    endfunction

    function automatic void kw_advance(logic [7:0] c);
        for (int k = 0; k < KW_N; k++) begin
            if (kw_word[k].len() <= lx_len || kw_word[k][lx_len] != c) lx_cands[k] = 1'b0;
        end
        if (lx_len != 4'd15) lx_len++;
    endfunction

    function automatic logic [5:0] word_kind();
        for (int k = 0; k < KW_N; k++) begin
            if (lx_cands[k] && kw_word[k].len() == lx_len) return 6'(K_KW0 + k);
        end
        return K_IDENT;
    endfunction

    function automatic void flush_pending(logic [19:0] off);
        logic [5:0] kind;
        bit err;
        err = 0;
        case (lx_mode)
            M_COLON: kind = K_COLON;
            M_EQ: kind = K_EQUAL;
            M_GT: kind = K_GT;
            M_LT: kind = K_LT;
            M_SLASH: kind = K_SLASH;
            M_DASH: kind = K_DASH;
            M_LPAREN: kind = K_LPAREN;
            M_INT, M_FRAC: kind = K_NUMBER;
            M_IDENT: kind = word_kind();
            M_PIPE: begin kind = E_PIPE; err = 1; end
            M_DOT: begin kind = E_FRAC; err = 1; end
            M_STR, M_STR_BS: begin kind = E_STRING; err = 1; end
            M_COM, M_COM_STAR: begin kind = E_COMMENT; err = 1; end
            default: begin
                lx_mode = M_IDLE;
                return;
            end
        endcase
        emit(kind, lx_start, off);
        lx_mode = err ? M_ERR : M_IDLE;
    endfunction

    function automatic void start_token(logic [7:0] c, logic [19:0] off);
        logic [19:0] e;
        e = offset_inc(off);
        lx_start = off;
        case (c)
            "{": begin emit(K_LBRACE, off, e); return; end
            "}": begin emit(K_RBRACE, off, e); return; end
            ")": begin emit(K_RPAREN, off, e); return; end
            ",": begin emit(K_COMMA, off, e); return; end
            "+": begin emit(K_PLUS, off, e); return; end
            "*": begin emit(K_STAR, off, e); return; end
            "_": begin emit(K_UNDER, off, e); return; end
            "(": begin lx_mode = M_LPAREN; return; end
            ":": begin lx_mode = M_COLON; return; end
            "=": begin lx_mode = M_EQ; return; end
            ">": begin lx_mode = M_GT; return; end
            "<": begin lx_mode = M_LT; return; end
            "-": begin lx_mode = M_DASH; return; end
            "/": begin lx_mode = M_SLASH; return; end
            "|": begin lx_mode = M_PIPE; return; end
            "\"": begin lx_mode = M_STR; return; end
            8'h0A: begin line_inc(); return; end
            " ": return;
            default: ;
        endcase
        if (digit_char(c)) begin
            lx_mode = M_INT;
            return;
        end
        if (word_char(c)) begin
            lx_mode = M_IDENT;
            lx_cands = 14'h3FFF;
            lx_len = '0;
            kw_advance(c);
            return;
        end
        emit(E_BYTE, off, e);
        lx_mode = M_ERR;
    endfunction

    function automatic bit continue_token(logic [7:0] c, logic [19:0] off);
        logic [5:0] pair;
        bit         hit;
        hit = 0;
        pair = '0;
        case (lx_mode)
            M_COLON: if (c == ":") begin pair = K_DCOLON; hit = 1; end
            M_EQ: begin
                if (c == ">") begin pair = K_ARROW; hit = 1; end
                else if (c == "=") begin pair = K_EQEQ; hit = 1; end
            end
            M_GT: if (c == "=") begin pair = K_GE; hit = 1; end
            M_LT: begin
                if (c == "=") begin pair = K_LE; hit = 1; end
                else if (c == "-") begin pair = K_LARROW; hit = 1; end
            end
            M_SLASH: if (c == "=") begin pair = K_NE; hit = 1; end
            M_PIPE: if (c == ">") begin pair = K_PIPEGT; hit = 1; end
            M_LPAREN: begin
                if (c == "*") begin
                    lx_mode = M_COM;
                    return 1;
                end
                return 0;
            end
            M_DASH, M_INT: begin
                if (digit_char(c)) begin
                    lx_mode = M_INT;
                    return 1;
                end
                if (lx_mode == M_INT && c == ".") begin
                    lx_mode = M_DOT;
                    return 1;
                end
                return 0;
            end
            M_DOT, M_FRAC: begin
                if (digit_char(c)) begin
                    lx_mode = M_FRAC;
                    return 1;
                end
                return 0;
            end
            M_IDENT: begin
                if (word_char(c)) begin
                    kw_advance(c);
                    return 1;
                end
                return 0;
            end
            M_STR, M_STR_BS: begin
                if (c == "\"" && lx_mode == M_STR) begin
                    emit(K_STRING, offset_inc(lx_start), off);
                    lx_mode = M_IDLE;
                    return 1;
                end
                if (c == 8'h0A) line_inc();
                lx_mode = (c == "\\") ? M_STR_BS : M_STR;
                return 1;
            end
            M_COM, M_COM_STAR: begin
                if (c == ")" && lx_mode == M_COM_STAR) begin
                    lx_mode = M_IDLE;
                    return 1;
                end
                if (c == 8'h0A) line_inc();
                lx_mode = (c == "*") ? M_COM_STAR : M_COM;
                return 1;
            end
            default: return 0;
        endcase
        if (hit) begin
            emit(pair, lx_start, offset_inc(off));
            lx_mode = M_IDLE;
            return 1;
        end
        return 0;
    endfunction

    function automatic void lex_byte(logic [7:0] c);
        logic [19:0] off;
        off = lx_offset;
        step_tokens.delete();
        if (c == 8'h00) begin
            if (lx_mode == M_LPAREN) emit(E_COMMENT, lx_start, off);
            else if (lx_mode != M_IDLE && lx_mode != M_ERR) flush_pending(off);
            emit(K_END, off, off);
            lex_restart();
        end else begin
            if (lx_mode != M_ERR) begin
                if (lx_mode == M_IDLE) begin
                    start_token(c, off);
                end else if (!continue_token(c, off)) begin
                    flush_pending(off);
                    if (lx_mode == M_IDLE) start_token(c, off);
                end
            end
            lx_offset = offset_inc(off);
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
    endfunction

    // source side
    task automatic send_byte(input logic [7:0] c);
        while ($urandom_range(99) < tx_gap_pct) begin
            src_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        src_if.valid <= 1'b1;
        src_if.ch <= c;
        do @(posedge i_clk); while (!src_if.ready);
        lex_byte(c);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) text_add(s[i]);
    endtask

    task automatic send_text();
        while (text_q.size() > 0) send_byte(text_q.pop_front());
    endtask

    task automatic wait_idle();
        src_if.valid <= 1'b0;
        while (expected_tokens.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_first_line(input logic [15:0] v);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        first_line_reg = v;
    endtask

    task automatic random_token();
        int n;
        string two_ops[8] = '{"::", "==", "=>", ">=", "<=", "<-", "/=", "|>"};
        string one_ops = "{}(),:=<>+*_-/|";
        case ($urandom_range(0, 99)) inside
            [0:14]: text_add(one_ops[$urandom_range(0, one_ops.len() - 1)]);
            [15:24]: push_text(two_ops[$urandom_range(0, 7)]);
            [25:39]: begin
                if ($urandom_range(1)) text_add("-");
                repeat ($urandom_range(1, 3)) text_add(8'("0" + $urandom_range(9)));
                if ($urandom_range(2) == 0) begin
                    text_add(".");
                    n = $urandom_range(0, 2);
                    repeat (n) text_add(8'("0" + $urandom_range(9)));
                end
            end
            [40:49]: push_text(kw_word[$urandom_range(0, KW_N - 1)]);
            [50:59]: begin
                text_add(8'("a" + $urandom_range(25)));
                repeat ($urandom_range(0, 5)) begin
                    case ($urandom_range(3))
                        0: text_add(8'("0" + $urandom_range(9)));
                        1: text_add(8'("A" + $urandom_range(25)));
                        2: text_add($urandom_range(1) ? "." : "_");
                        default: text_add(8'("a" + $urandom_range(25)));
                    endcase
                end
            end
            [60:67]: begin
                text_add("\"");
                repeat ($urandom_range(0, 5)) begin
                    case ($urandom_range(5))
                        0: push_text("\\\"");
                        1: text_add(8'h0A);
                        default: text_add(8'($urandom_range(32, 126)));
                    endcase
                end
                if ($urandom_range(9) != 0) text_add("\"");
            end
            [68:73]: begin
                push_text("(*");
                repeat ($urandom_range(0, 4)) text_add(8'($urandom_range(1, 255)));
                if ($urandom_range(9) != 0) push_text("*)");
            end
            [74:87]: text_add($urandom_range(2) == 0 ? 8'h0A : " ");
            [88:93]: text_add(8'($urandom_range(1, 255)));
            default: text_add(8'h00);
        endcase
        if ($urandom_range(2) != 0) text_add(" ");
    endtask

    task automatic random_bytes(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            random_token();
            sent += text_q.size();
            send_text();
        end
        send_byte(8'h00);
    endtask

    // sink side
    always @(posedge i_clk) begin
        if (!hold_on) hold_cnt <= 0;
        else if (hold_cnt < HOLD_CYCLES) hold_cnt <= hold_cnt + 1;
    end

    always @(posedge i_clk) begin
        if (hold_on && hold_cnt < HOLD_CYCLES) tok_if.ready <= 1'b0;
        else tok_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        t_token got, want;
        if (i_rst_n && tok_if.valid && tok_if.ready) begin
            got = '{tok_if.kind, tok_if.start_offset, tok_if.end_offset, tok_if.line,
                    tok_if.last};
            if (expected_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token kind=%0d start=%0d end=%0d line=%0d last=%0d",
                             got.kind, got.start_offset, got.end_offset, got.line,
                             got.last);
            end else begin
                want = expected_tokens.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("token mismatch exp kind=%0d start=%0d end=%0d line=%0d last=%0d",
                                 want.kind, want.start_offset, want.end_offset, want.line,
                                 want.last);
                        $display("               got kind=%0d start=%0d end=%0d line=%0d last=%0d",
                                 got.kind, got.start_offset, got.end_offset, got.line,
                                 got.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        push_text("{}(),:::= ==>>>=<<=<-+*_-/ /=|>");
        push_text(" -12.5 7 \"a\\\"b\nc\" (* x\n*) let or andx\n");
        text_add(8'h00);
        send_text();
        push_text("3.x");
        text_add(8'h00);
        push_text("|a");
        text_add(8'h00);
        text_add("(");
        text_add(8'h00);
        push_text("(*");
        text_add(8'h00);
        push_text("\"ab");
        text_add(8'h00);
        text_add(8'h09);
        text_add(8'hFF);
        text_add(8'h00);
        send_text();
        foreach (kw_word[k]) begin
            push_text(kw_word[k]);
            text_add(" ");
        end
        text_add(8'h00);
        send_text();
    endtask

    task automatic test_first_line();
        write_first_line(16'hFFFE);
        send_byte(8'h00);
        push_text("a\n\n\nb");
        text_add(8'h00);
        send_text();
        write_first_line(16'h0000);
        send_byte(8'h00);
        push_text("x\ny");
        text_add(8'h00);
        send_text();
        write_first_line(16'hFFFF);
        random_bytes(60);
        write_first_line(16'h1234);
        send_byte(8'h00);
    endtask

    task automatic test_random_phases();
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        random_bytes(120);
        tx_gap_pct = 68;
        random_bytes(100);
        tx_gap_pct = 0;
        rx_stall_pct = 68;
        random_bytes(100);
        tx_gap_pct = 15;
        rx_stall_pct = 15;
        random_bytes(100);
    endtask

    task automatic test_output_hold();
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        hold_on = 1;
        random_bytes(60);
        wait_idle();
        hold_on = 0;
        write_first_line(16'h0001);
    endtask

    initial begin
        src_if.valid = 1'b0;
        src_if.ch = 8'h00;
        tok_if.ready = 1'b0;
        lex_restart();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_first_line();
        test_random_phases();
        test_output_hold();
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/stok_pkg.sv
rtl/stok_if.sv
rtl/stok_kw.sv
rtl/source_tokenizer_top.sv
dv/testbench.sv
